// ----- design/gtg_pkg.sv -----
// Shared types, constants and the arctangent table of the go-to-goal controller.
// No dependencies; every other file of the block imports this package.
package gtg_pkg;

   // CORDIC iteration count: default of the top-level parameter (range 8..24)
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_TABLE_LEN   = 24;
   localparam int NORM_STEPS       = 5;
   // square root: one add stage plus one stage per root bit
   localparam int SQRT_LAT         = 33;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // angles in 2^-30 rad
   localparam logic signed [33:0] ANG_PI     = 34'sd3373259426;
   localparam logic signed [35:0] ANG_PI_W   = 36'sd3373259426;
   localparam logic signed [35:0] ANG_TWO_PI = 36'sd6746518852;

   // configuration register indexes
   localparam logic [2:0] CSR_GOAL_X     = 3'd0;
   localparam logic [2:0] CSR_GOAL_Y     = 3'd1;
   localparam logic [2:0] CSR_LIN_GAIN   = 3'd2;
   localparam logic [2:0] CSR_ANG_GAIN   = 3'd3;
   localparam logic [2:0] CSR_DIST_TOL   = 3'd4;
   localparam logic [2:0] CSR_HEAD_TOL   = 3'd5;

   localparam logic [15:0] LIN_GAIN_RST  = 16'd26214;
   localparam logic [15:0] ANG_GAIN_RST  = 16'd49152;
   localparam logic [31:0] DIST_TOL_RST  = 32'd6554;
   localparam logic [14:0] HEAD_TOL_RST  = 15'd410;

   typedef enum logic [1:0] {
      MODE_DRIVE_TURN = 2'd0,
      MODE_STRAIGHT   = 2'd1,
      MODE_STOPPED    = 2'd2
   } drive_mode_type;

   typedef struct packed {
      logic signed [31:0] goal_x;
      logic signed [31:0] goal_y;
      logic [15:0]        linear_gain;
      logic [15:0]        angular_gain;
      logic [31:0]        distance_tolerance;
      logic [14:0]        heading_tolerance;
   } ctrl_cfg_type;

   // one classified sample as it waits between front and back
   typedef struct packed {
      logic [63:0]        sq_x;       // ex^2
      logic [63:0]        sq_y;       // ey^2
      logic signed [33:0] ex;
      logic signed [33:0] ey;
      logic signed [33:0] yaw_vx;
      logic signed [33:0] yaw_vy;
      logic               yaw_lock;   // gimbal lock, yaw forced to zero
   } work_item_type;

   typedef struct packed {
      logic                   empty;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

   function automatic logic [29:0] atan_entry(input logic [4:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0:  val = 30'h3243F6A8;
         5'd1:  val = 30'h1DAC6705;
         5'd2:  val = 30'h0FADBAFC;
         5'd3:  val = 30'h07F56EA6;
         5'd4:  val = 30'h03FEAB76;
         5'd5:  val = 30'h01FFD55B;
         5'd6:  val = 30'h00FFFAAA;
         5'd7:  val = 30'h007FFF55;
         5'd8:  val = 30'h003FFFEA;
         5'd9:  val = 30'h001FFFFD;
         5'd10: val = 30'h000FFFFF;
         5'd11: val = 30'h0007FFFF;
         5'd12: val = 30'h0003FFFF;
         5'd13: val = 30'h0001FFFF;
         5'd14: val = 30'h0000FFFF;
         5'd15: val = 30'h00007FFF;
         5'd16: val = 30'h00003FFF;
         5'd17: val = 30'h00001FFF;
         5'd18: val = 30'h00000FFF;
         5'd19: val = 30'h000007FF;
         5'd20: val = 30'h000003FF;
         5'd21: val = 30'h000001FF;
         5'd22: val = 30'h000000FF;
         5'd23: val = 30'h0000007F;
         default: val = 30'h0;
      endcase
      return val;
   endfunction

endpackage

// ----- design/gtg_front.sv -----
// Front end: accepts pose samples, forms goal offsets, squares and yaw vector.
// Depends on gtg_pkg; pushes one work item per sample into gtg_queue.
module gtg_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [127:0]              req_tdata,
   input  gtg_pkg::ctrl_cfg_type     cfg,
   input  gtg_pkg::queue_status_type q_status,
   output logic                      push,
   output gtg_pkg::work_item_type    push_item
);
   import gtg_pkg::*;

   logic f1_vld_ff, f2_vld_ff;
   logic signed [33:0] ex_ff, ey_ff, ex_in, ey_in;
   logic [31:0] ax_ff, ay_ff, ax_in, ay_in;
   logic signed [31:0] p_xx_ff, p_yy_ff, p_zz_ff, p_ww_ff;
   logic signed [31:0] p_xz_ff, p_wy_ff, p_xy_ff, p_wz_ff;
   logic signed [15:0] qx, qy, qz, qw;
   logic signed [33:0] d_sum, g_val, g_abs;
   logic [QUEUE_CNT_W+1:0] in_flight;
   logic accept;
   work_item_type item_ff, item_in;

   assign qx = req_tdata[79:64];
   assign qy = req_tdata[95:80];
   assign qz = req_tdata[111:96];
   assign qw = req_tdata[127:112];

   // credit check: queue entries plus samples still in the two front stages
   assign in_flight = (QUEUE_CNT_W+2)'(q_status.count) + (QUEUE_CNT_W+2)'(f1_vld_ff)
                    + (QUEUE_CNT_W+2)'(f2_vld_ff);
   assign req_tready = in_flight < (QUEUE_CNT_W+2)'(QUEUE_DEPTH);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      ex_in = 34'(cfg.goal_x) - 34'($signed(req_tdata[31:0]));
      ey_in = 34'(cfg.goal_y) - 34'($signed(req_tdata[63:32]));
      ax_in = ex_in[33] ? 32'(-ex_in) : ex_in[31:0];
      ay_in = ey_in[33] ? 32'(-ey_in) : ey_in[31:0];
   end

   always_ff @(posedge clock) begin
      ex_ff   <= ex_in;
      ey_ff   <= ey_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      p_xx_ff <= qx * qx;
      p_yy_ff <= qy * qy;
      p_zz_ff <= qz * qz;
      p_ww_ff <= qw * qw;
      p_xz_ff <= qx * qz;
      p_wy_ff <= qw * qy;
      p_xy_ff <= qx * qy;
      p_wz_ff <= qw * qz;
   end

   always_comb begin
      d_sum = 34'(p_xx_ff) + 34'(p_yy_ff) + 34'(p_zz_ff) + 34'(p_ww_ff);
      g_val = (34'(p_xz_ff) - 34'(p_wy_ff)) <<< 1;
      g_abs = g_val[33] ? -g_val : g_val;
      item_in.sq_x     = 64'(ax_ff) * 64'(ax_ff);
      item_in.sq_y     = 64'(ay_ff) * 64'(ay_ff);
      item_in.ex       = ex_ff;
      item_in.ey       = ey_ff;
      item_in.yaw_vx   = 34'(p_ww_ff) + 34'(p_xx_ff) - 34'(p_yy_ff) - 34'(p_zz_ff);
      item_in.yaw_vy   = (34'(p_xy_ff) + 34'(p_wz_ff)) <<< 1;
      item_in.yaw_lock = g_abs >= d_sum;
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else begin
         f1_vld_ff <= accept;
         f2_vld_ff <= f1_vld_ff;
      end
   end

   assign push      = f2_vld_ff;
   assign push_item = item_ff;

endmodule

// ----- design/gtg_queue.sv -----
// Short work queue between front and back end.
// Depends on gtg_pkg for the item type and depth.
module gtg_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  gtg_pkg::work_item_type    push_item,
   input  logic                      pop,
   output gtg_pkg::work_item_type    head,
   output gtg_pkg::queue_status_type status
);
   import gtg_pkg::*;

   work_item_type mem_ff [0:QUEUE_DEPTH-1];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.empty = (cnt_ff == '0);
   assign status.count = cnt_ff;

endmodule

// ----- design/gtg_cordic.sv -----
// Pipelined CORDIC vectoring atan2: mirror, five normalize stages, STEPS rotations.
// Depends on gtg_pkg for the arctangent table; the result passes through PAD delay registers.
module gtg_cordic #(
   parameter int STEPS   = gtg_pkg::CORDIC_STEPS_DEF,
   parameter int LATENCY = gtg_pkg::SQRT_LAT
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [33:0] in_x,
   input  logic signed [33:0] in_y,
   input  logic               in_force_zero,
   output logic signed [33:0] z_out
);
   import gtg_pkg::*;

   localparam int LAST = NORM_STEPS + STEPS;
   localparam int PAD  = LATENCY - LAST - 1;

   logic signed [36:0] sx_ff [0:LAST];
   logic signed [36:0] sy_ff [0:LAST];
   logic signed [33:0] sz_ff [0:LAST];
   logic               szero_ff [0:LAST];
   logic [32:0]        sm_ff [0:NORM_STEPS];

   logic signed [33:0] mir_x, mir_y, mir_z, abs_y;
   logic signed [33:0] z_res;

   // mirror into the right half plane
   always_comb begin
      mir_x = in_x[33] ? -in_x : in_x;
      mir_y = in_x[33] ? -in_y : in_y;
      mir_z = in_x[33] ? (in_y[33] ? -ANG_PI : ANG_PI) : 34'sd0;
      abs_y = mir_y[33] ? -mir_y : mir_y;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff[0]    <= 37'(mir_x);
         sy_ff[0]    <= 37'(mir_y);
         sz_ff[0]    <= mir_z;
         szero_ff[0] <= in_force_zero || (in_x == '0 && in_y == '0);
         sm_ff[0]    <= (abs_y > mir_x) ? abs_y[32:0] : mir_x[32:0];
      end
   end

   // normalize: shift by 16, 8, 4, 2, 1 while the larger part stays below 2^32
   for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
      localparam int SH = 16 >> k;
      localparam logic [32:0] LIM = 33'd1 << (32 - SH);
      always_ff @(posedge clock) begin
         if (en) begin
            if (sm_ff[k] < LIM) begin
               sx_ff[k+1] <= sx_ff[k] <<< SH;
               sy_ff[k+1] <= sy_ff[k] <<< SH;
               sm_ff[k+1] <= sm_ff[k] << SH;
            end else begin
               sx_ff[k+1] <= sx_ff[k];
               sy_ff[k+1] <= sy_ff[k];
               sm_ff[k+1] <= sm_ff[k];
            end
            sz_ff[k+1]    <= sz_ff[k];
            szero_ff[k+1] <= szero_ff[k];
         end
      end
   end

   // rotations toward y = 0
   for (genvar i = 0; i < STEPS; i++) begin : g_iter
      localparam int S = NORM_STEPS + i;
      localparam logic signed [33:0] ANG = $signed({4'b0, atan_entry(5'(i))});
      always_ff @(posedge clock) begin
         if (en) begin
            if (sy_ff[S] > 37'sd0) begin
               sx_ff[S+1] <= sx_ff[S] + (sy_ff[S] >>> i);
               sy_ff[S+1] <= sy_ff[S] - (sx_ff[S] >>> i);
               sz_ff[S+1] <= sz_ff[S] + ANG;
            end else begin
               sx_ff[S+1] <= sx_ff[S] - (sy_ff[S] >>> i);
               sy_ff[S+1] <= sy_ff[S] + (sx_ff[S] >>> i);
               sz_ff[S+1] <= sz_ff[S] - ANG;
            end
            szero_ff[S+1] <= szero_ff[S];
         end
      end
   end

   assign z_res = szero_ff[LAST] ? 34'sd0 : sz_ff[LAST];

   if (PAD > 0) begin : g_pad
      logic signed [33:0] pad_ff [0:PAD-1];
      always_ff @(posedge clock) begin
         if (en) begin
            pad_ff[0] <= z_res;
            for (int j = 1; j < PAD; j++) begin
               pad_ff[j] <= pad_ff[j-1];
            end
         end
      end
      assign z_out = pad_ff[PAD-1];
   end else begin : g_nopad
      assign z_out = z_res;
   end

endmodule

// ----- design/gtg_sqrt.sv -----
// Pipelined integer square root of ex^2 + ey^2, one root bit per stage.
// Depends on gtg_pkg for SQRT_LAT; saturates when the sum overflows 64 bits.
module gtg_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] sq_x,
   input  logic [63:0] sq_y,
   output logic [31:0] dist_out
);
   import gtg_pkg::*;

   localparam int BITS = SQRT_LAT - 1;

   logic [63:0] rem_ff  [0:BITS];
   logic [31:0] root_ff [0:BITS];
   logic        sat_ff  [0:BITS];
   logic [64:0] sum;

   assign sum = {1'b0, sq_x} + {1'b0, sq_y};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= sum[63:0];
         root_ff[0] <= '0;
         sat_ff[0]  <= sum[64];
      end
   end

   for (genvar j = 0; j < BITS; j++) begin : g_bit
      localparam int K = BITS - 1 - j;
      logic [65:0] trial;
      assign trial = ({34'b0, root_ff[j]} << (K + 1)) + (66'd1 << (2 * K));
      always_ff @(posedge clock) begin
         if (en) begin
            if ({2'b0, rem_ff[j]} >= trial) begin
               rem_ff[j+1]  <= rem_ff[j] - trial[63:0];
               root_ff[j+1] <= root_ff[j] | (32'd1 << K);
            end else begin
               rem_ff[j+1]  <= rem_ff[j];
               root_ff[j+1] <= root_ff[j];
            end
            sat_ff[j+1] <= sat_ff[j];
         end
      end
   end

   assign dist_out = sat_ff[BITS] ? '1 : root_ff[BITS];

endmodule

// ----- design/gtg_back.sv -----
// Back end: distance and angle units, heading wrap, gains, mode and result register.
// Depends on gtg_pkg, gtg_cordic and gtg_sqrt; pops work items from gtg_queue.
module gtg_back #(
   parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  gtg_pkg::ctrl_cfg_type     cfg,
   input  gtg_pkg::work_item_type    head,
   input  gtg_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [87:0]               rsp_tdata
);
   import gtg_pkg::*;

   logic adv;
   logic vld_ff [0:SQRT_LAT-1];
   logic signed [33:0] bearing, yaw;
   logic [31:0] dist_val;

   logic e1_vld_ff, e2_vld_ff, e3_vld_ff, e4_vld_ff;
   logic signed [35:0] e_ff, ew_ff, ew_in;
   logic [31:0] d1_ff, d2_ff, d3_ff, d4_ff;
   logic signed [18:0] he_ff, he4_ff;
   logic [18:0] hmag_ff;
   logic [47:0] lin_p_ff;
   logic far_ff, far4_ff, turn_ff;
   logic [16:0] lin_ff;
   logic [32:0] lin_r;
   logic signed [35:0] ang_p_ff, ang_r, he_rnd;
   logic signed [17:0] ang_c;
   logic [16:0] lin_o;
   logic signed [17:0] ang_o;
   drive_mode_type mode;
   logic rsp_tvalid_ff;
   logic [87:0] rsp_tdata_ff, rsp_tdata_in;

   // the whole back pipeline moves only while the result register can take a value
   assign adv = !rsp_tvalid_ff || rsp_tready;
   assign pop = adv && !q_status.empty;

   gtg_cordic #(.STEPS(CORDIC_STEPS), .LATENCY(SQRT_LAT)) u_bearing (
      .clock(clock), .en(adv), .in_x(head.ex), .in_y(head.ey),
      .in_force_zero(1'b0), .z_out(bearing)
   );

   gtg_cordic #(.STEPS(CORDIC_STEPS), .LATENCY(SQRT_LAT)) u_yaw (
      .clock(clock), .en(adv), .in_x(head.yaw_vx), .in_y(head.yaw_vy),
      .in_force_zero(head.yaw_lock), .z_out(yaw)
   );

   gtg_sqrt u_dist (
      .clock(clock), .en(adv), .sq_x(head.sq_x), .sq_y(head.sq_y), .dist_out(dist_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SQRT_LAT; i++) vld_ff[i] <= 1'b0;
         e1_vld_ff <= 1'b0;
         e2_vld_ff <= 1'b0;
         e3_vld_ff <= 1'b0;
         e4_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= pop;
         for (int i = 1; i < SQRT_LAT; i++) vld_ff[i] <= vld_ff[i-1];
         e1_vld_ff <= vld_ff[SQRT_LAT-1];
         e2_vld_ff <= e1_vld_ff;
         e3_vld_ff <= e2_vld_ff;
         e4_vld_ff <= e3_vld_ff;
      end
   end

   // heading wrap, once by 2pi
   always_comb begin
      if (e_ff > ANG_PI_W) begin
         ew_in = e_ff - ANG_TWO_PI;
      end else if (e_ff < -ANG_PI_W) begin
         ew_in = e_ff + ANG_TWO_PI;
      end else begin
         ew_in = e_ff;
      end
      he_rnd = (ew_ff + 36'sd65536) >>> 17;
   end

   always_comb begin
      lin_r = 33'(({1'b0, lin_p_ff} + 49'd32768) >> 16);
      ang_r = (ang_p_ff + 36'sd4096) >>> 13;
      if (ang_r > 36'sd65536) begin
         ang_c = 18'sd65536;
      end else if (ang_r < -36'sd65536) begin
         ang_c = -18'sd65536;
      end else begin
         ang_c = ang_r[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // E1
         e_ff     <= 36'(bearing) - 36'(yaw);
         d1_ff    <= dist_val;
         // E2
         ew_ff    <= ew_in;
         d2_ff    <= d1_ff;
         // E3
         he_ff    <= he_rnd[18:0];
         hmag_ff  <= he_rnd[18] ? 19'(-he_rnd) : he_rnd[18:0];
         lin_p_ff <= 48'(cfg.linear_gain) * 48'(d2_ff);
         far_ff   <= d2_ff > cfg.distance_tolerance;
         d3_ff    <= d2_ff;
         // E4
         lin_ff   <= (lin_r > 33'd65536) ? 17'd65536 : lin_r[16:0];
         ang_p_ff <= $signed({1'b0, cfg.angular_gain}) * he_ff;
         turn_ff  <= hmag_ff > {4'b0, cfg.heading_tolerance};
         far4_ff  <= far_ff;
         he4_ff   <= he_ff;
         d4_ff    <= d3_ff;
      end
   end

   always_comb begin
      if (!far4_ff) begin
         mode  = MODE_STOPPED;
         lin_o = '0;
         ang_o = '0;
      end else if (turn_ff) begin
         mode  = MODE_DRIVE_TURN;
         lin_o = lin_ff;
         ang_o = ang_c;
      end else begin
         mode  = MODE_STRAIGHT;
         lin_o = lin_ff;
         ang_o = '0;
      end
      rsp_tdata_in = {3'b0, mode, he4_ff[15:0], d4_ff, ang_o, lin_o};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= e4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ----- design/go_to_goal_velocity_controller.sv -----
// Top level of the go-to-goal velocity controller: register file and the
// front end, work queue and back end. Depends on gtg_pkg and all gtg_ modules.
//
// Each pose sample on req_ (position plus orientation quaternion) yields one
// velocity command on rsp_. The block measures distance and bearing to the
// goal, takes yaw from the quaternion, wraps the heading error into +-pi,
// applies the proportional gains with clamping to +-1.0 and picks drive and
// turn, drive straight or stopped. Throughput is one sample per clock while
// rsp_ does not stall: the front end, the square-root pipeline (one root bit
// per stage) and the two CORDIC pipelines (one rotation per stage) all take a
// new sample every cycle. From req_ to rsp_ a sample passes two front stages,
// the queue, 33 stages of the distance/angle units, four combine stages and
// the result register. A stalled rsp_ side freezes the back end while the
// four-entry queue keeps taking samples until it is full. Configuration
// writes are taken on any cycle with csr_we high; write them while idle.
module go_to_goal_velocity_controller #(
   parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x[31:0], pos_y[63:32], quat_x[79:64], quat_y[95:80],
   // quat_z[111:96], quat_w[127:112]
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // linear_speed[16:0], angular_speed[34:17], distance_error[66:35],
   // heading_error[82:67], drive_mode[84:83], zero fill [87:85]
   output logic [87:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import gtg_pkg::*;

   ctrl_cfg_type     cfg_ff, cfg_in;
   queue_status_type q_status;
   work_item_type    push_item, head;
   logic             push, pop;

   // register file, indexes as listed in the package
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GOAL_X:   cfg_in.goal_x             = csr_wdata;
            CSR_GOAL_Y:   cfg_in.goal_y             = csr_wdata;
            CSR_LIN_GAIN: cfg_in.linear_gain        = csr_wdata[15:0];
            CSR_ANG_GAIN: cfg_in.angular_gain       = csr_wdata[15:0];
            CSR_DIST_TOL: cfg_in.distance_tolerance = csr_wdata;
            CSR_HEAD_TOL: cfg_in.heading_tolerance  = csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.goal_x             <= '0;
         cfg_ff.goal_y             <= '0;
         cfg_ff.linear_gain        <= LIN_GAIN_RST;
         cfg_ff.angular_gain       <= ANG_GAIN_RST;
         cfg_ff.distance_tolerance <= DIST_TOL_RST;
         cfg_ff.heading_tolerance  <= HEAD_TOL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: offsets, squares, yaw vector and gimbal check
   gtg_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .cfg(cfg_ff), .q_status(q_status), .push(push), .push_item(push_item)
   );

   // decouples the front end from stalls on the result side
   gtg_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item),
      .pop(pop), .head(head), .status(q_status)
   );

   // back end: sqrt, two CORDICs, wrap, gains, mode, result register
   gtg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .head(head),
      .q_status(q_status), .pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

endmodule
